[src/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants for the I2C master bit engine
// Opcodes, bus phase codes, field widths and the reset half period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int unsigned HALF_PERIOD_W     = 16;
    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned BIT_CNT_W         = 4;
    localparam int unsigned OPCODE_W          = 3;
    localparam int unsigned IN_DATA_W         = 16;
    localparam int unsigned OUT_DATA_W        = 16;
    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd40;
    localparam logic [BIT_CNT_W-1:0]     LAST_BIT          = 4'd7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_SEND     = 3'd2,
        OP_READ     = 3'd3,
        OP_ACK_SMP  = 3'd4,
        OP_ACK_SEND = 3'd5,
        OP_PROBE    = 3'd6
    } opcode_t;

    typedef enum logic [4:0] {
        PH_IDLE          = 5'd0,
        PH_START_HI      = 5'd1,
        PH_START_SDA     = 5'd2,
        PH_START_SCL     = 5'd3,
        PH_STOP_SETUP    = 5'd4,
        PH_STOP_SDA      = 5'd5,
        PH_TX_DATA       = 5'd6,
        PH_TX_SCLH       = 5'd7,
        PH_TX_SCLL       = 5'd8,
        PH_RX_SCLH       = 5'd9,
        PH_RX_SCLL       = 5'd10,
        PH_ACKS_SCLH     = 5'd11,
        PH_ACKS_SCLL     = 5'd12,
        PH_ACKT_SDA      = 5'd13,
        PH_ACKT_SCLH     = 5'd14,
        PH_ACKT_SCLL     = 5'd15,
        PH_PR_START_HI   = 5'd16,
        PH_PR_START_SDA  = 5'd17,
        PH_PR_START_SCL  = 5'd18,
        PH_PR_TX_DATA    = 5'd19,
        PH_PR_TX_SCLH    = 5'd20,
        PH_PR_TX_SCLL    = 5'd21,
        PH_PR_ACK_SCLH   = 5'd22,
        PH_PR_ACK_SCLL   = 5'd23,
        PH_PR_STOP_SETUP = 5'd24,
        PH_PR_STOP_SDA   = 5'd25
    } phase_t;

endpackage

[src/i2c_master_bit_engine_core.sv]
// A tick's result is registered in the output register that drives m_tdata, or
// in the skid stage while the output is stalled. Throughput: one tick per cycle
// while the skid stage is empty; the phase update is a single combinational pass.
// Reset (aresetn low, synchronous): phase idle, SCL and SDA released, counters and
// received byte cleared, half period back to 40, no result pending.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core: tick-driven I2C master bit engine
// Sequences start, stop, byte send/read, ack sample/send and device probe,
// one bus tick per input transfer, one status result per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_bit_engine_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [i2cm_pkg::HALF_PERIOD_W-1:0]     cfg_wr_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [0] cmd_valid, [3:1] opcode, [11:4] tx_byte, [12] sda_in, [13] scl_in
    input  logic [i2cm_pkg::IN_DATA_W-1:0]         s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte, [12] nack
    output logic [i2cm_pkg::OUT_DATA_W-1:0]        m_tdata
);

    import i2cm_pkg::*;

    // input fields
    logic                 in_cmd_valid;
    opcode_t              in_opcode;
    logic [BYTE_W-1:0]    in_tx_byte;
    logic                 in_sda;
    logic                 in_scl;

    assign in_cmd_valid = s_tdata[0];
    assign in_opcode    = opcode_t'(s_tdata[3:1]);
    assign in_tx_byte   = s_tdata[11:4];
    assign in_sda       = s_tdata[12];
    assign in_scl       = s_tdata[13];

    // engine state
    logic [HALF_PERIOD_W-1:0] half_period_reg;
    phase_t                   phase_reg, phase_next;
    logic [BIT_CNT_W-1:0]     bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0]        shifter_reg, shifter_next;
    logic [HALF_PERIOD_W-1:0] delay_count_reg, delay_count_next;
    logic [BYTE_W-1:0]        rx_byte_reg, rx_byte_next;
    logic                     nack_reg, nack_next;
    logic                     scl_reg, scl_next;
    logic                     sda_reg, sda_next;
    logic                     done_c;

    // output register and skid stage
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]    out_data_reg, out_data_next;
    logic                     skid_valid_reg, skid_valid_next;
    logic [OUT_DATA_W-1:0]    skid_data_reg, skid_data_next;
    logic [OUT_DATA_W-1:0]    result_c;

    logic                     in_xfer;
    logic                     out_xfer;

    assign s_tready = ~skid_valid_reg;
    assign in_xfer  = s_tvalid & s_tready;
    assign out_xfer = out_valid_reg & m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        logic   enter_en;
        phase_t enter_ph;
        phase_t nxt;

        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shifter_next     = shifter_reg;
        delay_count_next = delay_count_reg;
        rx_byte_next     = rx_byte_reg;
        nack_next        = nack_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        done_c           = 1'b0;
        enter_en         = 1'b0;
        enter_ph         = PH_IDLE;
        nxt              = PH_IDLE;

        if (in_xfer) begin
            if (phase_reg == PH_IDLE) begin
                if (in_cmd_valid) begin
                    case (in_opcode)
                        OP_START: begin
                            enter_en = 1'b1;
                            enter_ph = PH_START_HI;
                        end
                        OP_STOP: begin
                            enter_en = 1'b1;
                            enter_ph = PH_STOP_SETUP;
                        end
                        OP_SEND: begin
                            shifter_next   = in_tx_byte;
                            bit_count_next = '0;
                            enter_en       = 1'b1;
                            enter_ph       = PH_TX_DATA;
                        end
                        OP_READ: begin
                            shifter_next   = '0;
                            bit_count_next = '0;
                            enter_en       = 1'b1;
                            enter_ph       = PH_RX_SCLH;
                        end
                        OP_ACK_SMP: begin
                            enter_en = 1'b1;
                            enter_ph = PH_ACKS_SCLH;
                        end
                        OP_ACK_SEND: begin
                            enter_en = 1'b1;
                            enter_ph = PH_ACKT_SDA;
                        end
                        OP_PROBE: begin
                            if (in_sda && in_scl) begin
                                shifter_next   = in_tx_byte;
                                bit_count_next = '0;
                                enter_en       = 1'b1;
                                enter_ph       = PH_PR_START_HI;
                            end else begin
                                // bus not idle: fail at once
                                nack_next = 1'b1;
                                done_c    = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end else if (delay_count_reg > HALF_PERIOD_W'(1)) begin
                delay_count_next = delay_count_reg - HALF_PERIOD_W'(1);
            end else begin
                case (phase_reg)
                    PH_START_HI:      nxt = PH_START_SDA;
                    PH_START_SDA:     nxt = PH_START_SCL;
                    PH_START_SCL:     nxt = PH_IDLE;
                    PH_PR_START_HI:   nxt = PH_PR_START_SDA;
                    PH_PR_START_SDA:  nxt = PH_PR_START_SCL;
                    PH_PR_START_SCL: begin
                        bit_count_next = '0;
                        nxt            = PH_PR_TX_DATA;
                    end
                    PH_STOP_SETUP:    nxt = PH_STOP_SDA;
                    PH_STOP_SDA:      nxt = PH_IDLE;
                    PH_PR_STOP_SETUP: nxt = PH_PR_STOP_SDA;
                    PH_PR_STOP_SDA:   nxt = PH_IDLE;
                    PH_TX_DATA:       nxt = PH_TX_SCLH;
                    PH_TX_SCLH:       nxt = PH_TX_SCLL;
                    PH_PR_TX_DATA:    nxt = PH_PR_TX_SCLH;
                    PH_PR_TX_SCLH:    nxt = PH_PR_TX_SCLL;
                    PH_TX_SCLL, PH_PR_TX_SCLL: begin
                        shifter_next = {shifter_reg[BYTE_W-2:0], 1'b0};
                        if (bit_count_reg == LAST_BIT) begin
                            nxt = (phase_reg == PH_TX_SCLL) ? PH_IDLE : PH_PR_ACK_SCLH;
                        end else begin
                            bit_count_next = bit_count_reg + BIT_CNT_W'(1);
                            nxt = (phase_reg == PH_TX_SCLL) ? PH_TX_DATA : PH_PR_TX_DATA;
                        end
                    end
                    PH_RX_SCLH: begin
                        // sample at the end of SCL high, MSB first
                        shifter_next = {shifter_reg[BYTE_W-2:0], in_sda};
                        nxt          = PH_RX_SCLL;
                    end
                    PH_RX_SCLL: begin
                        if (bit_count_reg == LAST_BIT) begin
                            rx_byte_next = shifter_reg;
                            nxt          = PH_IDLE;
                        end else begin
                            bit_count_next = bit_count_reg + BIT_CNT_W'(1);
                            nxt            = PH_RX_SCLH;
                        end
                    end
                    PH_ACKS_SCLH: begin
                        nack_next = in_sda;
                        nxt       = PH_ACKS_SCLL;
                    end
                    PH_PR_ACK_SCLH: begin
                        nack_next = in_sda;
                        nxt       = PH_PR_ACK_SCLL;
                    end
                    PH_ACKS_SCLL:     nxt = PH_IDLE;
                    PH_PR_ACK_SCLL:   nxt = PH_PR_STOP_SETUP;
                    PH_ACKT_SDA:      nxt = PH_ACKT_SCLH;
                    PH_ACKT_SCLH:     nxt = PH_ACKT_SCLL;
                    PH_ACKT_SCLL: begin
                        sda_next = 1'b1;
                        nxt      = PH_IDLE;
                    end
                    default:          nxt = PH_IDLE;
                endcase

                if (nxt == PH_IDLE) begin
                    phase_next       = PH_IDLE;
                    delay_count_next = '0;
                    done_c           = 1'b1;
                end else begin
                    enter_en = 1'b1;
                    enter_ph = nxt;
                end
            end

            if (enter_en) begin
                phase_next       = enter_ph;
                delay_count_next = (half_period_reg == '0) ? HALF_PERIOD_W'(1)
                                                           : half_period_reg;
                // line change on entry to a phase
                case (enter_ph)
                    PH_START_HI, PH_PR_START_HI, PH_ACKS_SCLH, PH_PR_ACK_SCLH,
                    PH_RX_SCLH: begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    PH_START_SDA, PH_PR_START_SDA, PH_ACKT_SDA: sda_next = 1'b0;
                    PH_START_SCL, PH_PR_START_SCL, PH_RX_SCLL, PH_ACKS_SCLL,
                    PH_PR_ACK_SCLL, PH_ACKT_SCLL: scl_next = 1'b0;
                    PH_STOP_SETUP, PH_PR_STOP_SETUP: begin
                        sda_next = 1'b0;
                        scl_next = 1'b1;
                    end
                    PH_STOP_SDA, PH_PR_STOP_SDA: sda_next = 1'b1;
                    PH_TX_DATA, PH_PR_TX_DATA: sda_next = shifter_next[BYTE_W-1];
                    PH_TX_SCLH, PH_PR_TX_SCLH, PH_ACKT_SCLH: scl_next = 1'b1;
                    PH_TX_SCLL, PH_PR_TX_SCLL: begin
                        scl_next = 1'b0;
                        // release SDA after the eighth bit
                        if (bit_count_next == LAST_BIT) begin
                            sda_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // result word and output staging
    // ------------------------------------------------------------------
    always_comb begin
        result_c = {3'b000, nack_next, rx_byte_next, done_c,
                    (phase_next != PH_IDLE), sda_next, scl_next};
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_xfer || !out_valid_reg) begin
            // drain skid first, then take the fresh result
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_xfer;
                out_data_next  = result_c;
            end
        end else if (in_xfer) begin
            skid_valid_next = 1'b1;
            skid_data_next  = result_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            shifter_reg     <= '0;
            delay_count_reg <= '0;
            rx_byte_reg     <= '0;
            nack_reg        <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                half_period_reg <= cfg_wr_data;
            end
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            shifter_reg     <= shifter_next;
            delay_count_reg <= delay_count_next;
            rx_byte_reg     <= rx_byte_next;
            nack_reg        <= nack_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_skid_implies_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds data while output register is empty");

    a_stall_fills_skid : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result lost while output was stalled");

    a_delay_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> (delay_count_reg != '0))
        else $error("active phase with zero hold count");

    a_bit_count_range : assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= LAST_BIT)
        else $error("bit counter past the last bit");

    a_hold_without_tick : assert property (@(posedge aclk) disable iff (!aresetn)
        !in_xfer |=> $stable(phase_reg) && $stable(delay_count_reg))
        else $error("engine state moved without an accepted tick");

endmodule

[bench/i2cm_bit_engine_checker.sv]
// ----------------------------------------------------------------------------
// i2cm_bit_engine_checker: bus status predictor and scoreboard
// Watches the tick and status streams of the I2C master bit engine. It
// mirrors the bus sequencer for every accepted tick and compares each
// accepted status transfer, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cm_bit_engine_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [i2cm_pkg::HALF_PERIOD_W-1:0] cfg_wr_data,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [i2cm_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [i2cm_pkg::OUT_DATA_W-1:0]    m_tdata,
    output int unsigned                        error_count,
    output int unsigned                        pending_count
);

    import i2cm_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    // scl_out lowest, nack highest, same order as the status stream
    typedef struct packed {
        logic             nack;
        logic [BYTE_W-1:0] rx_byte;
        logic             done;
        logic             busy;
        logic             sda;
        logic             scl;
    } bus_status_t;

    bus_status_t expected_status_q[$];

    logic [HALF_PERIOD_W-1:0] half_period;
    phase_t                   phase;
    logic [BIT_CNT_W-1:0]     bit_cnt;
    logic [BYTE_W-1:0]        shift_byte;
    logic [HALF_PERIOD_W-1:0] hold_cnt;
    logic [BYTE_W-1:0]        rx_hold;
    logic                     nack_hold;
    logic                     scl_lvl;
    logic                     sda_lvl;

    initial begin
        error_count   = 0;
        pending_count = 0;
    end

    // Drive the lines for a new bus phase and restart its hold time
    task automatic enter_phase(input phase_t next_phase);
        phase = next_phase;
        case (next_phase)
            PH_START_HI, PH_PR_START_HI, PH_RX_SCLH, PH_ACKS_SCLH, PH_PR_ACK_SCLH: begin
                sda_lvl = 1'b1;
                scl_lvl = 1'b1;
            end
            PH_START_SDA, PH_PR_START_SDA, PH_ACKT_SDA: sda_lvl = 1'b0;
            PH_START_SCL, PH_PR_START_SCL, PH_RX_SCLL, PH_ACKS_SCLL,
            PH_PR_ACK_SCLL, PH_ACKT_SCLL: scl_lvl = 1'b0;
            PH_STOP_SETUP, PH_PR_STOP_SETUP: begin
                sda_lvl = 1'b0;
                scl_lvl = 1'b1;
            end
            PH_STOP_SDA, PH_PR_STOP_SDA: sda_lvl = 1'b1;
            PH_TX_DATA, PH_PR_TX_DATA: sda_lvl = shift_byte[BYTE_W-1];
            PH_TX_SCLH, PH_PR_TX_SCLH, PH_ACKT_SCLH: scl_lvl = 1'b1;
            PH_TX_SCLL, PH_PR_TX_SCLL: begin
                scl_lvl = 1'b0;
                // release SDA once the eighth bit is clocked out
                if (bit_cnt == LAST_BIT) sda_lvl = 1'b1;
            end
            default: ;
        endcase
        hold_cnt = (half_period == '0) ? HALF_PERIOD_W'(1) : half_period;
    endtask

    task automatic predict_tick(input logic [IN_DATA_W-1:0] tick, output bus_status_t status);
        logic              cmd;
        logic [OPCODE_W-1:0] op;
        logic [BYTE_W-1:0] tx;
        logic              sda_in;
        logic              scl_in;
        logic              done;
        phase_t            next_phase;
        cmd    = tick[0];
        op     = tick[3:1];
        tx     = tick[11:4];
        sda_in = tick[12];
        scl_in = tick[13];
        done   = 1'b0;
        if (phase == PH_IDLE) begin
            if (cmd) begin
                case (op)
                    OP_START:    enter_phase(PH_START_HI);
                    OP_STOP:     enter_phase(PH_STOP_SETUP);
                    OP_SEND: begin
                        shift_byte = tx;
                        bit_cnt    = '0;
                        enter_phase(PH_TX_DATA);
                    end
                    OP_READ: begin
                        shift_byte = '0;
                        bit_cnt    = '0;
                        enter_phase(PH_RX_SCLH);
                    end
                    OP_ACK_SMP:  enter_phase(PH_ACKS_SCLH);
                    OP_ACK_SEND: enter_phase(PH_ACKT_SDA);
                    OP_PROBE: begin
                        if (sda_in && scl_in) begin
                            shift_byte = tx;
                            bit_cnt    = '0;
                            enter_phase(PH_PR_START_HI);
                        end else begin
                            // bus not idle: fail at once, lines untouched
                            nack_hold = 1'b1;
                            done      = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (hold_cnt > 1) begin
            hold_cnt = hold_cnt - 1'b1;
        end else begin
            case (phase)
                PH_START_HI:      next_phase = PH_START_SDA;
                PH_START_SDA:     next_phase = PH_START_SCL;
                PH_START_SCL:     next_phase = PH_IDLE;
                PH_PR_START_HI:   next_phase = PH_PR_START_SDA;
                PH_PR_START_SDA:  next_phase = PH_PR_START_SCL;
                PH_PR_START_SCL: begin
                    bit_cnt    = '0;
                    next_phase = PH_PR_TX_DATA;
                end
                PH_STOP_SETUP:    next_phase = PH_STOP_SDA;
                PH_STOP_SDA:      next_phase = PH_IDLE;
                PH_PR_STOP_SETUP: next_phase = PH_PR_STOP_SDA;
                PH_PR_STOP_SDA:   next_phase = PH_IDLE;
                PH_TX_DATA:       next_phase = PH_TX_SCLH;
                PH_TX_SCLH:       next_phase = PH_TX_SCLL;
                PH_PR_TX_DATA:    next_phase = PH_PR_TX_SCLH;
                PH_PR_TX_SCLH:    next_phase = PH_PR_TX_SCLL;
                PH_TX_SCLL, PH_PR_TX_SCLL: begin
                    shift_byte = {shift_byte[BYTE_W-2:0], 1'b0};
                    if (bit_cnt == LAST_BIT) begin
                        next_phase = (phase == PH_TX_SCLL) ? PH_IDLE : PH_PR_ACK_SCLH;
                    end else begin
                        bit_cnt    = bit_cnt + 1'b1;
                        next_phase = (phase == PH_TX_SCLL) ? PH_TX_DATA : PH_PR_TX_DATA;
                    end
                end
                PH_RX_SCLH: begin
                    shift_byte = {shift_byte[BYTE_W-2:0], sda_in};
                    next_phase = PH_RX_SCLL;
                end
                PH_RX_SCLL: begin
                    if (bit_cnt == LAST_BIT) begin
                        rx_hold    = shift_byte;
                        next_phase = PH_IDLE;
                    end else begin
                        bit_cnt    = bit_cnt + 1'b1;
                        next_phase = PH_RX_SCLH;
                    end
                end
                PH_ACKS_SCLH: begin
                    nack_hold  = sda_in;
                    next_phase = PH_ACKS_SCLL;
                end
                PH_PR_ACK_SCLH: begin
                    nack_hold  = sda_in;
                    next_phase = PH_PR_ACK_SCLL;
                end
                PH_ACKS_SCLL:     next_phase = PH_IDLE;
                PH_PR_ACK_SCLL:   next_phase = PH_PR_STOP_SETUP;
                PH_ACKT_SDA:      next_phase = PH_ACKT_SCLH;
                PH_ACKT_SCLH:     next_phase = PH_ACKT_SCLL;
                PH_ACKT_SCLL: begin
                    sda_lvl    = 1'b1;
                    next_phase = PH_IDLE;
                end
                default:          next_phase = PH_IDLE;
            endcase
            if (next_phase == PH_IDLE) begin
                phase    = PH_IDLE;
                hold_cnt = '0;
                done     = 1'b1;
            end else begin
                enter_phase(next_phase);
            end
        end
        status.scl     = scl_lvl;
        status.sda     = sda_lvl;
        status.busy    = (phase != PH_IDLE);
        status.done    = done;
        status.rx_byte = rx_hold;
        status.nack    = nack_hold;
    endtask

    always @(posedge aclk) begin : watch_channels
        bus_status_t want;
        bus_status_t got;
        if (!aresetn) begin
            half_period = HALF_PERIOD_RESET;
            phase       = PH_IDLE;
            bit_cnt     = '0;
            shift_byte  = '0;
            hold_cnt    = '0;
            rx_hold     = '0;
            nack_hold   = 1'b0;
            scl_lvl     = 1'b1;
            sda_lvl     = 1'b1;
            expected_status_q.delete();
        end else begin
            if (cfg_wr_en) half_period = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got = bus_status_t'(m_tdata[$bits(bus_status_t)-1:0]);
                if (expected_status_q.size() == 0) begin
                    if (error_count < REPORT_LIMIT)
                        $display("status transfer %h with no tick pending", m_tdata);
                    error_count++;
                end else begin
                    want = expected_status_q.pop_front();
                    if (got.scl !== want.scl || got.sda !== want.sda ||
                        got.busy !== want.busy || got.done !== want.done ||
                        got.rx_byte !== want.rx_byte || got.nack !== want.nack) begin
                        if (error_count < REPORT_LIMIT)
                            $display({"status mismatch: expected scl=%0b sda=%0b busy=%0b ",
                                      "done=%0b rx=%02h nack=%0b, got scl=%0b sda=%0b ",
                                      "busy=%0b done=%0b rx=%02h nack=%0b"},
                                     want.scl, want.sda, want.busy, want.done,
                                     want.rx_byte, want.nack, got.scl, got.sda,
                                     got.busy, got.done, got.rx_byte, got.nack);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_tick(s_tdata, want);
                expected_status_q.push_back(want);
            end
        end
        pending_count = expected_status_q.size();
    end

endmodule

[bench/tb_i2c_master_bit_engine_core.sv]
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine_core: stimulus and verdict for the bit engine
// Runs every bus command under several half periods, first directed and
// then random, with random gaps and stalls on both streams, while the
// checker predicts and compares every status transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine_core;
    import i2cm_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
    localparam int unsigned BUSY_BIT       = 2;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned RANDOM_PHASES  = 5;
    localparam int unsigned TICKS_PER_PHASE = 90;
    // sda during the idle ticks of a command
    localparam int unsigned SDA_LOW  = 0;
    localparam int unsigned SDA_HIGH = 1;
    localparam int unsigned SDA_RAND = 2;

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [HALF_PERIOD_W-1:0] cfg_wr_data = '0;
    logic                     s_tvalid    = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_W-1:0]     s_tdata     = '0;
    logic                     m_tvalid;
    logic                     m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0]    m_tdata;

    int unsigned error_count;
    int unsigned pending_count;
    int unsigned ticks_sent   = 0;
    int unsigned status_seen  = 0;
    logic        bus_busy     = 1'b0;
    bit          no_idling    = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned half_now     = 32'(HALF_PERIOD_RESET);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    i2c_master_bit_engine_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    i2cm_bit_engine_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // transfer counters, updated late in the step so readers see settled values
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) ticks_sent <= ticks_sent + 1;
        if (m_tvalid && m_tready) begin
            status_seen <= status_seen + 1;
            bus_busy    <= m_tdata[BUSY_BIT];
        end
    end

    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) return $urandom_range(1, 2);
        if (pick < 95) return $urandom_range(3, 8);
        return $urandom_range(10, 40);
    endfunction

    // bus phases a command runs through, each held for one half period
    function automatic int unsigned cmd_ticks(input logic [OPCODE_W-1:0] op);
        int unsigned phases;
        case (op)
            OP_START:    phases = 3;
            OP_STOP:     phases = 2;
            OP_SEND:     phases = 24;
            OP_READ:     phases = 16;
            OP_ACK_SMP:  phases = 2;
            OP_ACK_SEND: phases = 3;
            OP_PROBE:    phases = 31;
            default:     phases = 0;
        endcase
        return phases * ((half_now == 0) ? 1 : half_now) + 1;
    endfunction

    task automatic push_tick(input logic cmd, input logic [OPCODE_W-1:0] op,
                             input logic [BYTE_W-1:0] tx, input logic sda, input logic scl);
        int unsigned gap;
        gap = (no_idling || $urandom_range(0, 9) < 7) ? 0 : gap_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, scl, sda, tx, op, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic push_idle(input int unsigned sda_mode);
        push_tick(1'b0, OPCODE_W'($urandom_range(0, 7)), BYTE_W'($urandom),
                  (sda_mode == SDA_RAND) ? 1'($urandom_range(0, 1)) : (sda_mode == SDA_HIGH),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic run_cmd(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] tx,
                           input logic sda, input logic scl, input int unsigned sda_mode);
        push_tick(1'b1, op, tx, sda, scl);
        repeat (cmd_ticks(op)) push_idle(sda_mode);
    endtask

    task automatic wait_status_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (ticks_sent != status_seen);
    endtask

    // tick the engine until the last status reports an idle bus
    task automatic settle_bus();
        wait_status_drained();
        while (bus_busy) begin
            push_idle(SDA_RAND);
            wait_status_drained();
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_half_period(input int unsigned value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= HALF_PERIOD_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        half_now     = value;
        @(posedge aclk);
    endtask

    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (!no_idling && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("tb_i2c_master_bit_engine_core: errors");
        $finish;
    end

    initial begin : stimulus
        logic                cmd;
        logic [OPCODE_W-1:0] op;
        logic                sda;
        logic                scl;
        int unsigned         halves[RANDOM_PHASES];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset half period
        run_cmd(OP_STOP, 8'h00, 1'b1, 1'b1, SDA_RAND);
        settle_bus();

        write_half_period(1);
        run_cmd(OP_START, 8'h5A, 1'b1, 1'b1, SDA_RAND);
        run_cmd(OP_SEND, 8'hFF, 1'b0, 1'b0, SDA_RAND);
        run_cmd(OP_SEND, 8'h00, 1'b1, 1'b1, SDA_RAND);
        run_cmd(OP_SEND, 8'hA5, 1'b0, 1'b1, SDA_RAND);
        run_cmd(OP_ACK_SMP, 8'h00, 1'b0, 1'b0, SDA_LOW);
        run_cmd(OP_ACK_SMP, 8'hFF, 1'b1, 1'b0, SDA_HIGH);
        run_cmd(OP_READ, 8'h00, 1'b1, 1'b1, SDA_HIGH);
        run_cmd(OP_READ, 8'hFF, 1'b0, 1'b0, SDA_LOW);
        run_cmd(OP_READ, 8'h3C, 1'b1, 1'b0, SDA_RAND);
        run_cmd(OP_ACK_SEND, 8'h00, 1'b1, 1'b1, SDA_RAND);
        run_cmd(OP_STOP, 8'hFF, 1'b0, 1'b1, SDA_RAND);
        // probe on an idle bus, device acks then device absent
        run_cmd(OP_PROBE, 8'hA0, 1'b1, 1'b1, SDA_LOW);
        run_cmd(OP_PROBE, 8'h5F, 1'b1, 1'b1, SDA_HIGH);
        // probe on a busy bus: SCL low, then SDA low
        run_cmd(OP_PROBE, 8'hA0, 1'b1, 1'b0, SDA_RAND);
        run_cmd(OP_PROBE, 8'hA0, 1'b0, 1'b1, SDA_RAND);
        run_cmd(OP_UNUSED, 8'hFF, 1'b1, 1'b1, SDA_RAND);
        // a command while another is running is dropped
        push_tick(1'b1, OP_SEND, 8'hC3, 1'b1, 1'b1);
        run_cmd(OP_START, 8'h00, 1'b1, 1'b1, SDA_RAND);
        repeat (cmd_ticks(OP_SEND)) push_idle(SDA_RAND);
        settle_bus();

        write_half_period(0);
        run_cmd(OP_START, 8'h00, 1'b1, 1'b1, SDA_RAND);
        run_cmd(OP_READ, 8'h00, 1'b0, 1'b1, SDA_RAND);
        settle_bus();

        write_half_period(2);
        run_cmd(OP_PROBE, 8'h81, 1'b1, 1'b1, SDA_RAND);
        settle_bus();

        // longest half period: only commands that finish at once
        write_half_period(65535);
        push_tick(1'b1, OP_PROBE, 8'h00, 1'b0, 1'b0);
        push_tick(1'b1, OP_UNUSED, 8'hFF, 1'b1, 1'b1);
        repeat (8) push_idle(SDA_RAND);
        settle_bus();

        halves[0] = 1;
        halves[1] = 2;
        halves[2] = $urandom_range(1, 4);
        halves[3] = 3;
        halves[4] = $urandom_range(1, 8);
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_half_period(halves[p]);
            no_idling = (p == 3);
            for (int t = 0; t < TICKS_PER_PHASE; t++) begin
                if (p == 1 && t == 50) hold_request = 1'b1;
                if (p == 2 && t == 60) wait_status_drained();
                cmd = ($urandom_range(0, 4) == 0);
                op  = ($urandom_range(0, 15) == 0) ? OP_UNUSED : OPCODE_W'($urandom_range(0, 6));
                sda = 1'($urandom_range(0, 1));
                scl = 1'($urandom_range(0, 1));
                // favor an idle bus so most probes run
                if (cmd && op == OP_PROBE && $urandom_range(0, 3) != 0) begin
                    sda = 1'b1;
                    scl = 1'b1;
                end
                push_tick(cmd, op, BYTE_W'($urandom), sda, scl);
            end
            no_idling = 1'b0;
            settle_bus();
        end

        repeat (10) @(posedge aclk);
        if (error_count == 0 && pending_count == 0) begin
            $display("tb_i2c_master_bit_engine_core: clean");
        end else begin
            $display("tb_i2c_master_bit_engine_core: errors");
        end
        $finish;
    end

endmodule

[i2c_master_bit_engine_core.f]
src/i2cm_pkg.sv
src/i2c_master_bit_engine_core.sv
bench/i2cm_bit_engine_checker.sv
bench/tb_i2c_master_bit_engine_core.sv
